// File: hdl/swma_pkg.sv
// shared constants, types and pointer helpers for the middle-access stack
`default_nettype none
package swma_pkg;

    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W = 7;

    // lower half holds the bottom ceil(n/2) words, upper half the rest
    localparam int LDEPTH  = (DEPTH + 1) / 2;
    localparam int UDEPTH  = DEPTH / 2;
    localparam int LAW     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int UAW     = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_DEL_MID = 2'd2,
        OP_REPORT  = 2'd3
    } t_op;

    // circular pointer step for the upper half
    function automatic logic [UAW-1:0] u_inc(input logic [UAW-1:0] x);
        logic [UAW-1:0] r;
        if (x == UAW'(UDEPTH - 1)) begin
            r = '0;
        end else begin
            r = x + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [UAW-1:0] u_dec(input logic [UAW-1:0] x);
        logic [UAW-1:0] r;
        if (x == '0) begin
            r = UAW'(UDEPTH - 1);
        end else begin
            r = x - 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/swma_ram.sv
// simple dual-port ram, one write and one registered read per cycle
`default_nettype none
module swma_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hdl/stack_with_middle_access_top.sv
// top level of the bounded stack with delete-middle access
//
// usage: a request is taken at a rising edge with start high and busy low.
// i_op selects push, pop top, delete middle or report; i_push_value is only
// used by push. each request produces exactly one response, shown on the
// o_ ports for a single cycle with o_valid high; the receiver cannot stall,
// so it must take the response in that cycle.
// timing: a request passes through the modify, re-read and respond states;
// o_valid goes high as the sequencer returns to idle, and a new request can
// be taken at the edge that takes the response, in the cycle that o_valid is
// shown. the states come from the read-modify-write of the two word rams:
// read the words that move, write them back, re-read the new top and middle.
// organization: the words below and at the middle live in a lower ram used
// as a stack; the words above the middle live in an upper ram used as a
// circular queue. every operation moves at most one word across the split.
// reset: the count and pointers clear, the rams keep whatever they held and
// a word is only used once it has been written. busy is low right after reset.
`default_nettype none
module stack_with_middle_access_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [swma_pkg::OP_W-1:0]           i_op,
    input  wire logic signed [swma_pkg::DATA_W-1:0]  i_push_value,
    output logic                                     o_valid,
    output logic signed [swma_pkg::DATA_W-1:0]       o_removed_value,
    output logic signed [swma_pkg::DATA_W-1:0]       o_top_value,
    output logic signed [swma_pkg::DATA_W-1:0]       o_middle_value,
    output logic [swma_pkg::OUT_CNT_W-1:0]           o_entry_count,
    output logic                                     o_empty_error,
    output logic                                     o_full_error
);

    localparam int CW  = swma_pkg::CNT_W;
    localparam int DW  = swma_pkg::DATA_W;
    localparam int LAW = swma_pkg::LAW;
    localparam int UAW = swma_pkg::UAW;

    // one-hot sequencer: idle, modify/write, re-read, respond
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOVE = 4'b0010,
        S_RD2  = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // stack bookkeeping
    logic [CW-1:0]  r_count, n_count;
    logic [UAW-1:0] r_head,  n_head;   // front (lowest) word of the upper half
    logic [UAW-1:0] r_tail,  n_tail;   // slot just above the top word

    // latched request and step results
    swma_pkg::t_op   r_op;
    logic [DW-1:0]   r_val;
    logic [DW-1:0]   r_removed, n_removed;
    logic            r_empty_err, n_empty_err;
    logic            r_full_err,  n_full_err;

    // response registers
    logic            r_valid;
    logic [DW-1:0]   r_top_out, r_mid_out, r_rem_out;
    logic [swma_pkg::OUT_CNT_W-1:0] r_cnt_out;
    logic            r_emp_out, r_full_out;

    // ram ports
    logic            l_we, u_we;
    logic [LAW-1:0]  l_waddr, l_raddr;
    logic [UAW-1:0]  u_waddr, u_raddr;
    logic [DW-1:0]   l_wdata, u_wdata, l_rdata, u_rdata;

    logic            accept;
    logic [CW:0]     count_p1;
    logic [LAW-1:0]  lower_top_idx;    // index of the middle word
    logic [LAW-1:0]  lower_next_idx;   // first free lower slot at an even count
    logic            cnt_zero, cnt_one, cnt_even, cnt_full;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    assign count_p1       = {1'b0, r_count} + 1'b1;
    assign lower_top_idx  = LAW'((count_p1 >> 1) - 1'b1);
    assign lower_next_idx = LAW'(r_count >> 1);
    assign cnt_zero       = (r_count == '0);
    assign cnt_one        = (r_count == CW'(1));
    assign cnt_even       = ~r_count[0];
    assign cnt_full       = (r_count == CW'(swma_pkg::DEPTH));

    // lower ram is always read at the middle; upper ram at its front in idle
    // for all but a pop (a push or delete may pull it down), else at its top
    assign l_raddr = lower_top_idx;
    assign u_raddr = (r_state == S_IDLE && i_op != swma_pkg::OP_POP) ?
                     r_head : swma_pkg::u_dec(r_tail);

    // modify step: decide the writes and the new pointers
    always_comb begin
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_removed   = '0;
        n_empty_err = 1'b0;
        n_full_err  = 1'b0;
        l_we        = 1'b0;
        l_waddr     = lower_next_idx;
        l_wdata     = u_rdata;
        u_we        = 1'b0;
        u_waddr     = r_tail;
        u_wdata     = r_val;

        if (r_state == S_MOVE) begin
            case (r_op)
                swma_pkg::OP_PUSH: begin
                    if (cnt_full) begin
                        n_full_err = 1'b1;
                    end else if (cnt_zero) begin
                        // first word goes straight to the lower half
                        l_we    = 1'b1;
                        l_waddr = '0;
                        l_wdata = r_val;
                        n_count = r_count + 1'b1;
                    end else if (cnt_even) begin
                        // upper front slides down to become the new middle
                        l_we    = 1'b1;
                        l_waddr = lower_next_idx;
                        l_wdata = u_rdata;
                        n_head  = swma_pkg::u_inc(r_head);
                        u_we    = 1'b1;
                        n_tail  = swma_pkg::u_inc(r_tail);
                        n_count = r_count + 1'b1;
                    end else begin
                        u_we    = 1'b1;
                        n_tail  = swma_pkg::u_inc(r_tail);
                        n_count = r_count + 1'b1;
                    end
                end
                swma_pkg::OP_POP: begin
                    if (cnt_zero) begin
                        n_empty_err = 1'b1;
                    end else if (cnt_one) begin
                        n_removed = l_rdata;
                        n_count   = r_count - 1'b1;
                    end else if (!cnt_even) begin
                        // top leaves the upper half, middle moves up into it
                        n_removed = u_rdata;
                        n_tail    = swma_pkg::u_dec(r_tail);
                        u_we      = 1'b1;
                        u_waddr   = swma_pkg::u_dec(r_head);
                        u_wdata   = l_rdata;
                        n_head    = swma_pkg::u_dec(r_head);
                        n_count   = r_count - 1'b1;
                    end else begin
                        n_removed = u_rdata;
                        n_tail    = swma_pkg::u_dec(r_tail);
                        n_count   = r_count - 1'b1;
                    end
                end
                swma_pkg::OP_DEL_MID: begin
                    if (cnt_zero) begin
                        n_empty_err = 1'b1;
                    end else begin
                        n_removed = l_rdata;
                        n_count   = r_count - 1'b1;
                        if (cnt_even) begin
                            // upper front fills the hole left by the middle
                            l_we    = 1'b1;
                            l_waddr = lower_top_idx;
                            l_wdata = u_rdata;
                            n_head  = swma_pkg::u_inc(r_head);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_MOVE;
            S_MOVE:  n_state = S_RD2;
            S_RD2:   n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_valid <= (r_state == S_RESP);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= swma_pkg::t_op'(i_op);
            r_val <= i_push_value;
        end
        if (r_state == S_MOVE) begin
            r_removed   <= n_removed;
            r_empty_err <= n_empty_err;
            r_full_err  <= n_full_err;
        end
        if (r_state == S_RESP) begin
            r_rem_out  <= r_removed;
            r_emp_out  <= r_empty_err;
            r_full_out <= r_full_err;
            r_cnt_out  <= swma_pkg::OUT_CNT_W'(r_count);
            if (cnt_zero) begin
                r_top_out <= '0;
                r_mid_out <= '0;
            end else begin
                r_top_out <= cnt_one ? l_rdata : u_rdata;
                r_mid_out <= l_rdata;
            end
        end
    end

    swma_ram #(
        .DEPTH  (swma_pkg::LDEPTH),
        .ADDR_W (LAW),
        .DATA_W (DW)
    ) u_lower_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    swma_ram #(
        .DEPTH  (swma_pkg::UDEPTH),
        .ADDR_W (UAW),
        .DATA_W (DW)
    ) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    assign o_valid         = r_valid;
    assign o_removed_value = r_rem_out;
    assign o_top_value     = r_top_out;
    assign o_middle_value  = r_mid_out;
    assign o_entry_count   = r_cnt_out;
    assign o_empty_error   = r_emp_out;
    assign o_full_error    = r_full_out;

endmodule
`default_nettype wire

// File: hdl/swma_checker.sv
// port-level checks for the middle-access stack, bound to the top level
`default_nettype none
module swma_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                o_valid,
    input wire logic signed [swma_pkg::DATA_W-1:0]  o_top_value,
    input wire logic signed [swma_pkg::DATA_W-1:0]  o_middle_value,
    input wire logic [swma_pkg::OUT_CNT_W-1:0]      o_entry_count,
    input wire logic                                o_empty_error,
    input wire logic                                o_full_error
);

    // every accepted request must be followed by its response
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("response missing four cycles after request");

    // response is a one-cycle strobe
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("o_valid held longer than one cycle");

    // both error flags never together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_empty_error && o_full_error))
        else $error("empty and full error both set");

    // an empty stack reports zero top and middle
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_entry_count == '0) |->
            (o_top_value == '0 && o_middle_value == '0))
        else $error("nonzero top or middle on empty stack");

endmodule

bind stack_with_middle_access_top swma_checker u_swma_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_top_value    (o_top_value),
    .o_middle_value (o_middle_value),
    .o_entry_count  (o_entry_count),
    .o_empty_error  (o_empty_error),
    .o_full_error   (o_full_error)
);
`default_nettype wire
